// ===== hdl/butterworth_lowpass_biquad_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the biquad low-pass block
// Concurrent checks, clocked on the rising edge, off while reset is low.
// ----------------------------------------------------------------------------
`ifndef BUTTERWORTH_LOWPASS_BIQUAD_DEFINES_SVH
`define BUTTERWORTH_LOWPASS_BIQUAD_DEFINES_SVH

// Same-cycle implication.
`define BWLP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define BWLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== hdl/bwlp_pkg.sv =====
// ----------------------------------------------------------------------------
// bwlp_pkg
// Shared constants, status codes and types of the biquad low-pass block.
// ----------------------------------------------------------------------------
`default_nettype none

package bwlp_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int TS_W             = 64;
    localparam int COEF_W           = 23;
    localparam int STAT_W           = 2;

    localparam logic [COEF_W-1:0] COEF_RESET = 23'd65536;

    // Shared multiplier: 24x24 chunks over 48-bit operands.
    localparam int CHUNK_W = 24;
    localparam int OPER_W  = 2 * CHUNK_W;
    localparam int PROD_W  = 2 * OPER_W;

    localparam int DEN_W   = 48;
    localparam int CC_W    = 2 * COEF_W;
    localparam int S_W     = 41;
    localparam int S_SHIFT = 14;
    localparam int S_SUM_W = S_W + S_SHIFT;
    localparam int S_HALF  = 1 << (S_SHIFT - 1);
    localparam int Q_SHIFT = 32;

    // Numerator width beyond the sample width.
    localparam int NUM_EXTRA = 50;

    localparam logic [30:0]      SQRT2_Q30 = 31'd1518500250;
    localparam logic [DEN_W-1:0] ONE_Q32   = 48'h0001_0000_0000;
    localparam logic [DEN_W-1:0] TWO_Q32   = 48'h0002_0000_0000;

    localparam logic [STAT_W-1:0] STAT_UPDATED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FIRST   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_REPEAT  = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== hdl/bwlp_div.sv =====
// ----------------------------------------------------------------------------
// bwlp_div
// Restoring divider, one quotient bit per cycle, rounded and range-checked.
// ----------------------------------------------------------------------------
`default_nettype none

module bwlp_div #(
    parameter int SAMPLE_WIDTH = bwlp_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         start,
    input  logic [SAMPLE_WIDTH+bwlp_pkg::NUM_EXTRA-1:0]  mag,
    input  logic [bwlp_pkg::DEN_W-1:0]                   den,
    output bwlp_pkg::div_stat_t                          stat,
    output logic [SAMPLE_WIDTH-1:0]                      quot
);

    import bwlp_pkg::*;

    localparam int NUM_W = SAMPLE_WIDTH + NUM_EXTRA;
    localparam int LOW_W = SAMPLE_WIDTH - 1;
    localparam int HI_W  = NUM_W - LOW_W;
    localparam int CNT_W = $clog2(SAMPLE_WIDTH);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_ROUND} dstate_t;

    dstate_t                 state_reg, state_next;
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [LOW_W-1:0]        low_reg, low_next;
    logic [LOW_W-1:0]        q_reg, q_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    logic                    ovf_reg, ovf_next;
    logic [SAMPLE_WIDTH-1:0] quot_reg, quot_next;

    logic [HI_W-1:0]         hi;
    logic                    ovf_pre;
    logic [DEN_W:0]          trial;
    logic [DEN_W:0]          trial_sub;
    logic                    fits;
    logic                    round_up;
    logic [SAMPLE_WIDTH-1:0] q_full;

    assign hi        = mag[NUM_W-1:LOW_W];
    assign ovf_pre   = hi >= HI_W'(den);
    assign trial     = {rem_reg, low_reg[LOW_W-1]};
    assign fits      = trial >= {1'b0, den};
    assign trial_sub = trial - {1'b0, den};
    assign round_up  = {rem_reg, 1'b0} >= {1'b0, den};
    assign q_full    = {1'b0, q_reg} + SAMPLE_WIDTH'(round_up);

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        ovf_next   = ovf_reg;
        quot_next  = quot_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    if (ovf_pre)
                    begin
                        done_next = 1'b1;
                        ovf_next  = 1'b1;
                    end
                    else
                    begin
                        rem_next   = hi[DEN_W-1:0];
                        low_next   = mag[LOW_W-1:0];
                        q_next     = '0;
                        cnt_next   = CNT_W'(LOW_W);
                        state_next = D_RUN;
                    end
                end
            end
            D_RUN:
            begin
                rem_next = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
                low_next = {low_reg[LOW_W-2:0], 1'b0};
                q_next   = {q_reg[LOW_W-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = D_ROUND;
                end
            end
            D_ROUND:
            begin
                quot_next  = q_full;
                ovf_next   = q_full[SAMPLE_WIDTH-1];
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            rem_reg   <= '0;
            low_reg   <= '0;
            q_reg     <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            quot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            low_reg   <= low_next;
            q_reg     <= q_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            ovf_reg   <= ovf_next;
            quot_reg  <= quot_next;
        end
    end

    assign stat.busy = (state_reg != D_IDLE);
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
    assign quot      = quot_reg;

endmodule

`default_nettype wire

// ===== hdl/butterworth_lowpass_biquad.sv =====
// ----------------------------------------------------------------------------
// butterworth_lowpass_biquad
// Second-order low-pass filter on signed fixed-point samples with timestamps.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one sample and its timestamp per transfer; m_* returns one
//   result per input: the filter output in m_tdata and a status code in
//   m_tuser (updated, first sample skipped, repeated timestamp skipped).
//   cfg_* writes the prewarp coefficient and is always ready; it must be
//   written only while the filter is idle, which the block does not enforce.
//   A filtered item runs four multiplies on one 24x24 multiplier
//   (c*c, c*sqrt2, two feedback terms), then a restoring divide of one bit
//   per cycle, which stops at its start if the upper numerator bits already
//   overflow; the result then passes through the push state to the output.
//   A skipped item goes straight from idle to the push state.
//   s_tready rises with m_tvalid, so a new item enters only after the last
//   result is pushed; the next item may enter while a result still waits.
//   When the receiver stalls, the result holds in the output register and a
//   following result waits inside the block, with s_tready low, until it drains.
//   Reset clears the histories and the stored time and loads c = 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "butterworth_lowpass_biquad_defines.svh"

module butterworth_lowpass_biquad #(
    parameter int SAMPLE_WIDTH = bwlp_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bwlp_pkg::COEF_W-1:0]            cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // sample, timestamp
    input  logic [((SAMPLE_WIDTH+bwlp_pkg::TS_W+7)/8)*8-1:0] s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // filtered
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_tdata,
    // status
    output logic [bwlp_pkg::STAT_W-1:0]            m_tuser
);

    import bwlp_pkg::*;

    localparam int NUM_W = SAMPLE_WIDTH + NUM_EXTRA;
    localparam int SUM_W = SAMPLE_WIDTH + 2;
    localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_POST,
        ST_COEF,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PUSH
    } state_t;

    typedef enum logic [1:0] {OP_CC, OP_S, OP_Y2, OP_Y1} op_t;

    state_t                          state_reg, state_next;
    op_t                             op_reg, op_next;
    logic [1:0]                      cnt_reg, cnt_next;
    logic [COEF_W-1:0]               coef_reg, coef_next;
    logic signed [SAMPLE_WIDTH-1:0]  x0_reg, x0_next;
    logic signed [SAMPLE_WIDTH-1:0]  x1_reg, x1_next;
    logic signed [SAMPLE_WIDTH-1:0]  x2_reg, x2_next;
    logic signed [SAMPLE_WIDTH-1:0]  y1_reg, y1_next;
    logic signed [SAMPLE_WIDTH-1:0]  y2_reg, y2_next;
    logic [TS_W-1:0]                 last_time_reg, last_time_next;
    logic [OPER_W-1:0]               a_reg, a_next;
    logic [OPER_W-1:0]               b_reg, b_next;
    logic [PROD_W-1:0]               prod_reg, prod_next;
    logic                            prod_neg_reg, prod_neg_next;
    logic [CC_W-1:0]                 cc_reg, cc_next;
    logic [S_W-1:0]                  s_reg, s_next;
    logic [DEN_W-1:0]                den_reg, den_next;
    logic [DEN_W-1:0]                a1_mag_reg, a1_mag_next;
    logic                            a1_neg_reg, a1_neg_next;
    logic signed [NUM_W-1:0]         num_reg, num_next;
    logic signed [SAMPLE_WIDTH-1:0]  res_data_reg, res_data_next;
    logic [STAT_W-1:0]               res_stat_reg, res_stat_next;
    logic                            m_valid_reg, m_valid_next;
    logic [SAMPLE_WIDTH-1:0]         m_data_reg, m_data_next;
    logic [STAT_W-1:0]               m_stat_reg, m_stat_next;

    logic signed [SAMPLE_WIDTH-1:0]  in_sample;
    logic [TS_W-1:0]                 in_ts;
    logic [CHUNK_W-1:0]              a_chunk;
    logic [CHUNK_W-1:0]              b_chunk;
    logic [2*CHUNK_W-1:0]            partial;
    logic [PROD_W-1:0]               partial_ext;
    logic [1:0]                      chunk_pos;
    logic [PROD_W-1:0]               partial_sh;
    logic [S_SUM_W-1:0]              s_sum;
    logic [DEN_W-1:0]                den_calc;
    logic [DEN_W-1:0]                a2_calc;
    logic [DEN_W-1:0]                two_cc;
    logic signed [SUM_W-1:0]         x_sum;
    logic signed [NUM_W-1:0]         num_init;
    logic signed [NUM_W-1:0]         prod_ext;
    logic signed [NUM_W-1:0]         num_upd;
    logic [SAMPLE_WIDTH-1:0]         y1_mag;
    logic [SAMPLE_WIDTH-1:0]         y2_mag;
    logic [NUM_W-1:0]                num_mag;
    logic signed [SAMPLE_WIDTH-1:0]  y_new;
    logic                            div_start;
    div_stat_t                       div_stat;
    logic [SAMPLE_WIDTH-1:0]         div_quot;

    assign in_sample = signed'(s_tdata[SAMPLE_WIDTH-1:0]);
    assign in_ts     = s_tdata[SAMPLE_WIDTH+TS_W-1:SAMPLE_WIDTH];

    // shared multiplier, one chunk pair per cycle
    assign a_chunk     = cnt_reg[1] ? a_reg[OPER_W-1:CHUNK_W] : a_reg[CHUNK_W-1:0];
    assign b_chunk     = cnt_reg[0] ? b_reg[OPER_W-1:CHUNK_W] : b_reg[CHUNK_W-1:0];
    assign partial     = a_chunk * b_chunk;
    assign partial_ext = PROD_W'(partial);
    assign chunk_pos   = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};

    always_comb
    begin
        case (chunk_pos)
            2'd0:    partial_sh = partial_ext;
            2'd1:    partial_sh = partial_ext << CHUNK_W;
            default: partial_sh = partial_ext << (2 * CHUNK_W);
        endcase
    end

    assign s_sum    = S_SUM_W'(prod_reg) + S_SUM_W'(S_HALF);
    assign den_calc = ONE_Q32 + DEN_W'(cc_reg) + DEN_W'(s_reg);
    assign a2_calc  = ONE_Q32 + DEN_W'(cc_reg) - DEN_W'(s_reg);
    assign two_cc   = DEN_W'({cc_reg, 1'b0});

    assign x_sum    = SUM_W'(x2_reg) + (SUM_W'(x1_reg) <<< 1) + SUM_W'(x0_reg);
    assign num_init = NUM_W'(x_sum) <<< Q_SHIFT;
    assign prod_ext = NUM_W'(prod_reg);
    assign num_upd  = prod_neg_reg ? num_reg + prod_ext : num_reg - prod_ext;
    assign num_mag  = num_reg[NUM_W-1] ? -num_reg : num_reg;

    assign y1_mag = y1_reg[SAMPLE_WIDTH-1] ? -y1_reg : y1_reg;
    assign y2_mag = y2_reg[SAMPLE_WIDTH-1] ? -y2_reg : y2_reg;

    always_comb
    begin
        if (div_stat.ovf)
        begin
            y_new = num_reg[NUM_W-1] ? Y_MIN : Y_MAX;
        end
        else
        begin
            y_new = num_reg[NUM_W-1] ? -signed'(div_quot) : signed'(div_quot);
        end
    end

    assign div_start = (state_reg == ST_DIV_START);

    bwlp_div #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mag   (num_mag),
        .den   (den_reg),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        coef_next      = coef_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        x2_next        = x2_reg;
        y1_next        = y1_reg;
        y2_next        = y2_reg;
        last_time_next = last_time_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        prod_next      = prod_reg;
        prod_neg_next  = prod_neg_reg;
        cc_next        = cc_reg;
        s_next         = s_reg;
        den_next       = den_reg;
        a1_mag_next    = a1_mag_reg;
        a1_neg_next    = a1_neg_reg;
        num_next       = num_reg;
        res_data_next  = res_data_reg;
        res_stat_next  = res_stat_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_stat_next    = m_stat_reg;

        if (cfg_valid)
        begin
            coef_next = cfg_data;
        end

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    x2_next        = x1_reg;
                    x1_next        = x0_reg;
                    x0_next        = in_sample;
                    last_time_next = in_ts;
                    if (last_time_reg == '0 || in_ts == last_time_reg)
                    begin
                        res_data_next = y1_reg;
                        res_stat_next = (last_time_reg == '0) ? STAT_FIRST : STAT_REPEAT;
                        state_next    = ST_PUSH;
                    end
                    else
                    begin
                        a_next     = OPER_W'(coef_reg);
                        b_next     = OPER_W'(coef_reg);
                        prod_next  = '0;
                        cnt_next   = '0;
                        op_next    = OP_CC;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next = prod_reg + partial_sh;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                case (op_reg)
                    OP_CC:
                    begin
                        cc_next    = prod_reg[CC_W-1:0];
                        a_next     = OPER_W'(coef_reg);
                        b_next     = OPER_W'(SQRT2_Q30);
                        prod_next  = '0;
                        op_next    = OP_S;
                        state_next = ST_MUL;
                    end
                    OP_S:
                    begin
                        s_next     = s_sum[S_SUM_W-1:S_SHIFT];
                        state_next = ST_COEF;
                    end
                    OP_Y2:
                    begin
                        num_next      = num_upd;
                        a_next        = OPER_W'(a1_mag_reg);
                        b_next        = OPER_W'(y1_mag);
                        prod_neg_next = a1_neg_reg ^ y1_reg[SAMPLE_WIDTH-1];
                        prod_next     = '0;
                        op_next       = OP_Y1;
                        state_next    = ST_MUL;
                    end
                    default:
                    begin
                        num_next   = num_upd;
                        state_next = ST_DIV_START;
                    end
                endcase
            end
            ST_COEF:
            begin
                den_next    = den_calc;
                a1_neg_next = two_cc > TWO_Q32;
                a1_mag_next = (two_cc > TWO_Q32) ? two_cc - TWO_Q32 : TWO_Q32 - two_cc;
                num_next    = num_init;
                a_next      = OPER_W'(a2_calc);
                b_next      = OPER_W'(y2_mag);
                prod_neg_next = y2_reg[SAMPLE_WIDTH-1];
                prod_next   = '0;
                op_next     = OP_Y2;
                state_next  = ST_MUL;
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    y2_next       = y1_reg;
                    y1_next       = y_new;
                    res_data_next = y_new;
                    res_stat_next = STAT_UPDATED;
                    state_next    = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_data_reg;
                    m_stat_next  = res_stat_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_CC;
            cnt_reg       <= '0;
            coef_reg      <= COEF_RESET;
            x0_reg        <= '0;
            x1_reg        <= '0;
            x2_reg        <= '0;
            y1_reg        <= '0;
            y2_reg        <= '0;
            last_time_reg <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            prod_reg      <= '0;
            prod_neg_reg  <= 1'b0;
            cc_reg        <= '0;
            s_reg         <= '0;
            den_reg       <= '0;
            a1_mag_reg    <= '0;
            a1_neg_reg    <= 1'b0;
            num_reg       <= '0;
            res_data_reg  <= '0;
            res_stat_reg  <= STAT_UPDATED;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
            m_stat_reg    <= STAT_UPDATED;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            coef_reg      <= coef_next;
            x0_reg        <= x0_next;
            x1_reg        <= x1_next;
            x2_reg        <= x2_next;
            y1_reg        <= y1_next;
            y2_reg        <= y2_next;
            last_time_reg <= last_time_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            prod_reg      <= prod_next;
            prod_neg_reg  <= prod_neg_next;
            cc_reg        <= cc_next;
            s_reg         <= s_next;
            den_reg       <= den_next;
            a1_mag_reg    <= a1_mag_next;
            a1_neg_reg    <= a1_neg_next;
            num_reg       <= num_next;
            res_data_reg  <= res_data_next;
            res_stat_reg  <= res_stat_next;
            m_valid_reg   <= m_valid_next;
            m_data_reg    <= m_data_next;
            m_stat_reg    <= m_stat_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = OUT_W'(m_data_reg);
    assign m_tuser   = m_stat_reg;

    `BWLP_ASSERT_NEXT(a_accept_blocks, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `BWLP_ASSERT_IMPL(a_div_start_idle, clk, rst_n, div_start, !div_stat.busy)
    `BWLP_ASSERT_IMPL(a_div_done_wait, clk, rst_n, div_stat.done, state_reg == ST_DIV_WAIT)
    `BWLP_ASSERT_IMPL(a_status_code, clk, rst_n, m_tvalid,
        m_tuser == STAT_UPDATED || m_tuser == STAT_FIRST || m_tuser == STAT_REPEAT)

endmodule

`default_nettype wire

// ===== tb/butterworth_lowpass_biquad_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// butterworth_lowpass_biquad_test
// Self-checking bench for the biquad low-pass filter. Sample/timestamp
// transfers go in as random bursts, every output is predicted with exact
// integer math and checked against the result stream under random stalls,
// across several prewarp coefficient settings including both extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module butterworth_lowpass_biquad_test;
    import bwlp_pkg::*;

    localparam int SW            = 32;
    localparam int IN_W          = ((SW + TS_W + 7) / 8) * 8;
    localparam int OUT_W         = ((SW + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_ITEMS   = 150;

    typedef struct packed {
        logic [TS_W-1:0] stamp;
        logic [SW-1:0]   sample;
    } sample_item_t;

    typedef struct packed {
        logic [SW-1:0]     filtered;
        logic [STAT_W-1:0] status;
    } filter_out_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [COEF_W-1:0] cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic [STAT_W-1:0] m_tuser;

    sample_item_t sample_queue[$];
    filter_out_t  expected_out[$];
    sample_item_t next_item;
    filter_out_t  oldest_out;

    logic [SW-1:0]     x_hist [3];
    logic [SW-1:0]     y_hist [3];
    logic [TS_W-1:0]   last_stamp;
    logic [COEF_W-1:0] coef_model = COEF_RESET;

    int errors        = 0;
    int items_queued  = 0;
    int results_seen  = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int ready_cycle   = 0;

    butterworth_lowpass_biquad #(
        .SAMPLE_WIDTH(SW)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic filter_out_t lowpass_step(input logic [SW-1:0] x_new,
                                                 input logic [TS_W-1:0] stamp);
        filter_out_t         res;
        logic [63:0]         c;
        logic [63:0]         cc;
        logic [63:0]         s;
        logic [63:0]         den;
        longint              a1;
        longint              a2;
        longint              sum;
        logic signed [127:0] w_sum;
        logic signed [127:0] w_a1;
        logic signed [127:0] w_a2;
        logic signed [127:0] w_y1;
        logic signed [127:0] w_y2;
        logic signed [127:0] num;
        logic [127:0]        mag;
        logic [127:0]        den_w;
        logic [127:0]        q;
        logic [127:0]        r;
        logic [SW-1:0]       q_low;
        logic                neg;
        x_hist[2] = x_hist[1];
        x_hist[1] = x_hist[0];
        x_hist[0] = x_new;
        if (last_stamp == '0 || stamp == last_stamp)
        begin
            res.status   = (last_stamp == '0) ? STAT_FIRST : STAT_REPEAT;
            res.filtered = y_hist[0];
            last_stamp   = stamp;
            return res;
        end
        last_stamp = stamp;

        c   = 64'(coef_model);
        cc  = c * c;
        s   = (c * 64'(SQRT2_Q30) + 64'd8192) >> 14;
        den = 64'(ONE_Q32) + cc + s;
        a2  = longint'(64'(ONE_Q32) + cc - s);
        a1  = longint'(64'(TWO_Q32) - (cc << 1));
        sum = $signed(x_hist[2]) + 2 * $signed(x_hist[1]) + $signed(x_hist[0]);

        w_sum = sum;
        w_a1  = a1;
        w_a2  = a2;
        w_y1  = $signed(y_hist[0]);
        w_y2  = $signed(y_hist[1]);
        num   = (w_sum <<< 32) - w_a2 * w_y2 - w_a1 * w_y1;

        neg   = num[127];
        mag   = neg ? -num : num;
        den_w = 128'(den);
        q     = mag / den_w;
        r     = mag % den_w;
        if (r >= den_w - r)
        begin
            q = q + 128'd1;
        end
        q_low = q[SW-1:0];
        if (q >= (128'd1 << (SW - 1)))
        begin
            res.filtered = neg ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
        else
        begin
            res.filtered = neg ? -q_low : q_low;
        end
        res.status = STAT_UPDATED;

        y_hist[2] = y_hist[1];
        y_hist[1] = y_hist[0];
        y_hist[0] = res.filtered;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_model <= COEF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            coef_model <= cfg_data;
        end
    end

    // Sender: bursts of transfers separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left = 0;
            gap_left   = 0;
            x_hist     = '{default: '0};
            y_hist     = '{default: '0};
            last_stamp = '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_out.push_back(lowpass_step(s_tdata[SW-1:0], s_tdata[SW+TS_W-1:SW]));
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0 || sample_queue.size() == 0)
                begin
                    if (gap_left > 0)
                    begin
                        gap_left--;
                    end
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    next_item = sample_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_W'({next_item.stamp, next_item.sample});
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
                    end
                end
            end
        end
    end

    // Receiver: free-flowing stretches alternate with stretches of random stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            stall_left  = 0;
            ready_cycle = 0;
        end
        else
        begin
            ready_cycle++;
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!ready_cycle[9] && $urandom_range(0, 5) == 0)
                begin
                    stall_left = $urandom_range(1, 90);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_out.size() == 0)
            begin
                $error("unexpected result: filtered %0d, status %0d",
                       $signed(m_tdata[SW-1:0]), m_tuser);
                errors++;
            end
            else
            begin
                oldest_out = expected_out.pop_front();
                if (m_tdata[SW-1:0] !== oldest_out.filtered)
                begin
                    $error("filtered: expected %0d, actual %0d",
                           $signed(oldest_out.filtered), $signed(m_tdata[SW-1:0]));
                    errors++;
                end
                if (m_tuser !== oldest_out.status)
                begin
                    $error("status: expected %0d, actual %0d", oldest_out.status, m_tuser);
                    errors++;
                end
            end
        end
    end

    task automatic push_item(input logic [SW-1:0] sample, input logic [TS_W-1:0] stamp);
        sample_item_t item;
        item.sample = sample;
        item.stamp  = stamp;
        sample_queue.push_back(item);
        items_queued++;
    endtask

    task automatic write_coef(input logic [COEF_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (results_seen < items_queued)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly advancing timestamps; repeats, zeros and wild stamps mixed in.
    task automatic queue_random(input int count);
        logic [TS_W-1:0] run_stamp;
        logic [TS_W-1:0] prev_stamp;
        logic [TS_W-1:0] stamp;
        logic [SW-1:0]   sample;
        int              pick;
        run_stamp  = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd1000;
        prev_stamp = run_stamp;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                stamp = prev_stamp;
            end
            else if (pick < 9)
            begin
                stamp = '0;
            end
            else if (pick < 12)
            begin
                stamp = {$urandom, $urandom};
            end
            else
            begin
                run_stamp = run_stamp + 64'($urandom_range(1, 100000));
                stamp     = run_stamp;
            end
            prev_stamp = stamp;

            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                sample = {1'b0, {(SW-1){1'b1}}};
            end
            else if (pick == 1)
            begin
                sample = {1'b1, {(SW-1){1'b0}}};
            end
            else if (pick < 6)
            begin
                sample = $urandom;
            end
            else
            begin
                sample = SW'($urandom_range(0, 2097152)) - SW'(1048576);
            end
            push_item(sample, stamp);
        end
    endtask

    initial
    begin
        logic [COEF_W-1:0] coef_plan [8];
        logic [SW-1:0]     s_max;
        logic [SW-1:0]     s_min;
        s_max = {1'b0, {(SW-1){1'b1}}};
        s_min = {1'b1, {(SW-1){1'b0}}};
        coef_plan = '{23'd65536, 23'd0, 23'd6553600, 23'h7FFFFF,
                      23'd655, 23'd1, 23'd0, 23'd0};
        coef_plan[6] = COEF_W'($urandom_range(655, 6553600));
        coef_plan[7] = COEF_W'($urandom_range(655, 6553600));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        push_item(s_max, '0);
        push_item(s_min, '0);
        push_item('0, {TS_W{1'b1}});
        push_item(s_min, {TS_W{1'b1}});
        for (int i = 1; i <= 4; i++)
        begin
            push_item(s_min, TS_W'(i));
        end
        for (int i = 5; i <= 12; i++)
        begin
            push_item(s_max, TS_W'(i));
        end
        for (int i = 13; i <= 18; i++)
        begin
            push_item(s_min, TS_W'(i));
        end
        push_item(SW'(1234), '0);
        push_item(SW'(5678), '0);
        push_item(SW'(-42), TS_W'(20));
        push_item(SW'(99), TS_W'(21));
        wait_drained();

        foreach (coef_plan[i])
        begin
            write_coef(coef_plan[i]);
            queue_random(PHASE_ITEMS);
            wait_drained();
        end

        if (expected_out.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_out.size());
            errors++;
        end
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
